FILE: design/stti_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stti_pkg
// Shared types, widths and register defaults of the spectral tuner indicator.
// ----------------------------------------------------------------------------
package stti_pkg;

  // field widths
  localparam int unsigned CH_W    = 3;
  localparam int unsigned MAG_W   = 15;
  localparam int unsigned COLOR_W = 8;
  localparam int unsigned TD_W    = 16;

  // integrator widths
  localparam int unsigned LEVEL_W = 22;
  localparam int unsigned SLOPE_W = 23;

  // parameter defaults
  localparam int unsigned STRING_COUNT_DEF = 6;
  localparam int unsigned DECAY_SHIFT_DEF  = 5;

  // configuration registers
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 10;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BASELINE    = 3'd0,
    CFG_GAIN_SHIFT  = 3'd1,
    CFG_TUNE_WINDOW = 3'd2,
    CFG_DIFF_GAIN   = 3'd3,
    CFG_COLOR_SLOPE = 3'd4
  } stti_cfg_idx_e;

  localparam logic [7:0] BASELINE_RST    = 8'd40;
  localparam logic [3:0] GAIN_SHIFT_RST  = 4'd5;
  localparam logic [9:0] TUNE_WINDOW_RST = 10'd10;
  localparam logic [9:0] DIFF_GAIN_RST   = 10'd200;
  localparam logic [7:0] COLOR_SLOPE_RST = 8'd15;

  // divider geometry: 32-bit dividend, divisor is intensity + 1 (1..256)
  localparam int unsigned DIV_QW    = 32;
  localparam int unsigned DIV_DW    = 9;
  localparam int unsigned DIV_STEPS = 2;

  typedef struct packed {
    logic [CH_W-1:0]  channel;
    logic [MAG_W-1:0] center_mag;
    logic [MAG_W-1:0] upper_mag;
    logic [MAG_W-1:0] lower_mag;
  } stti_in_t;

  typedef struct packed {
    logic [COLOR_W-1:0]     red;
    logic [COLOR_W-1:0]     green;
    logic [COLOR_W-1:0]     blue;
    logic signed [TD_W-1:0] tonal_diff;
  } stti_out_t;

endpackage
`default_nettype wire

FILE: design/stti_stream_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stti_stream_if
// Valid/ready stream channel carrying one payload beat.
// ----------------------------------------------------------------------------
interface stti_stream_if #(
  parameter type payload_t = logic [7:0]
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: design/stti_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stti_div
// Unsigned restoring divider, DIV_STEPS quotient bits per cycle.
// ----------------------------------------------------------------------------
module stti_div (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        start_i,
  input  wire  [stti_pkg::DIV_QW-1:0] dividend_i,
  input  wire  [stti_pkg::DIV_DW-1:0] divisor_i,
  output logic                       done_o,
  output logic [stti_pkg::DIV_QW-1:0] quotient_o
);
  import stti_pkg::*;

  localparam int unsigned ITER  = DIV_QW / DIV_STEPS;
  localparam int unsigned CNT_W = $clog2(ITER);

  logic [DIV_QW-1:0] quo_q, quo_d;
  logic [DIV_DW-1:0] rem_q, rem_d;
  logic [DIV_DW-1:0] div_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              busy_q;
  logic              last;

  // quotient bits shift in at the bottom as dividend bits leave the top
  always_comb begin
    logic [DIV_DW:0] sh;
    quo_d = quo_q;
    rem_d = rem_q;
    for (int k = 0; k < DIV_STEPS; k++) begin
      sh    = {rem_d, quo_d[DIV_QW-1]};
      quo_d = {quo_d[DIV_QW-2:0], 1'b0};
      if (sh >= {1'b0, div_q}) begin
        rem_d    = DIV_DW'(sh - {1'b0, div_q});
        quo_d[0] = 1'b1;
      end else begin
        rem_d = sh[DIV_DW-1:0];
      end
    end
  end

  assign last = busy_q && (cnt_q == CNT_W'(ITER - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_o <= 1'b0;
    end else begin
      done_o <= last;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (last) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign quotient_o = quo_q;

endmodule
`default_nettype wire

FILE: design/spectral_tuner_indicator_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spectral_tuner_indicator_core
// Per-channel leaky integrators, tonal difference and LED colour for a tuner.
// ----------------------------------------------------------------------------
// Usage:
//   in_i   - one beat per spectral frame: channel and the three bin magnitudes.
//   out_o  - one beat per input beat: red, green, blue and tonal_diff.
//   cfg_*  - register writes, to be taken only while no frame is in flight;
//            the user must ensure this, the block does not enforce it.
// A sequencer steps one frame through integrator update, scaling, a 23x10
// multiply, a divide (16 restoring steps of two quotient bits each, then
// done) and colour shaping. in_i is ready only while the sequencer is idle,
// so a new frame is taken only once the previous one has left the sequence.
// The finished result sits in an output register; the next frame is taken
// while it waits. If the sink stalls, the following result waits at the end
// of its sequence until the output register frees up.
// Reset clears all integrators and restores the register defaults; there is
// no clearing pass, the block is ready in the first cycle after reset.
// ----------------------------------------------------------------------------
module spectral_tuner_indicator_core #(
  parameter int unsigned STRING_COUNT = stti_pkg::STRING_COUNT_DEF,
  parameter int unsigned DECAY_SHIFT  = stti_pkg::DECAY_SHIFT_DEF
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  stti_stream_if.sink                      in_i,
  stti_stream_if.source                    out_o,
  input  wire                              cfg_we_i,
  input  wire  [stti_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire  [stti_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import stti_pkg::*;

  localparam int unsigned SLOTS  = STRING_COUNT + 1;
  localparam int unsigned SLOT_W = $clog2(SLOTS);

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_UPD   = 8'b0000_0010,
    ST_SCALE = 8'b0000_0100,
    ST_MUL   = 8'b0000_1000,
    ST_DIV   = 8'b0001_0000,
    ST_SAT   = 8'b0010_0000,
    ST_FADE  = 8'b0100_0000,
    ST_OUT   = 8'b1000_0000
  } stti_state_e;

  stti_state_e state_q, state_d;

  // configuration
  logic [7:0] baseline_q;
  logic [3:0] gain_shift_q;
  logic [9:0] tune_window_q;
  logic [9:0] diff_gain_q;
  logic [7:0] color_slope_q;

  // integrator state
  logic [LEVEL_W-1:0]        level_q [SLOTS];
  logic signed [SLOPE_W-1:0] slope_q [SLOTS];

  // working registers
  logic [SLOT_W-1:0]         slot_q;
  logic [MAG_W-1:0]          center_q, upper_q, lower_q;
  logic [LEVEL_W-1:0]        lvl_q;
  logic signed [SLOPE_W-1:0] slp_q;
  logic [7:0]                intensity_q;
  logic [SLOPE_W-1:0]        mag_q;
  logic                      neg_q;
  logic signed [TD_W-1:0]    td_q;
  logic [7:0]                fade_q;
  logic                      in_tune_q, sharp_q;

  logic      out_valid_q;
  stti_out_t out_data_q;

  // ---- combinational datapath ----
  logic [LEVEL_W-1:0]        lvl_cur, lvl_new, lvl_sh;
  logic signed [SLOPE_W-1:0] slp_cur, slp_new, slp_sh;
  logic signed [MAG_W:0]     nb_diff;
  logic [7:0]                intensity_d;
  logic [LEVEL_W-1:0]        lvl_off;
  logic [SLOPE_W+9:0]        prod;
  logic                      div_start, div_done;
  logic [DIV_QW-1:0]         quotient;
  logic signed [TD_W-1:0]    td_d;
  logic [TD_W-1:0]           abs_td;
  logic [TD_W+7:0]           fade_prod;
  logic [7:0]                fade_d;
  logic [7:0]                r_c, g_c, b_c;
  logic                      out_load, slot_over;

  assign slot_over = (int'(in_i.data.channel) >= STRING_COUNT);

  assign lvl_cur = level_q[slot_q];
  assign slp_cur = slope_q[slot_q];
  assign nb_diff = $signed({1'b0, upper_q}) - $signed({1'b0, lower_q});
  assign lvl_new = lvl_cur + LEVEL_W'(center_q) - (lvl_cur >> DECAY_SHIFT);
  assign slp_new = slp_cur + SLOPE_W'(nb_diff) - (slp_cur >>> DECAY_SHIFT);

  assign lvl_sh  = lvl_q >> gain_shift_q;
  assign slp_sh  = slp_q >>> gain_shift_q;
  assign lvl_off = lvl_sh - LEVEL_W'(baseline_q);

  always_comb begin
    if (lvl_sh < LEVEL_W'(baseline_q)) begin
      intensity_d = 8'd0;
    end else if (lvl_off > LEVEL_W'(255)) begin
      intensity_d = 8'd255;
    end else begin
      intensity_d = lvl_off[7:0];
    end
  end

  assign prod      = mag_q * diff_gain_q;
  assign div_start = (state_q == ST_MUL);

  stti_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (DIV_QW'(prod)),
    .divisor_i  ({1'b0, intensity_q} + DIV_DW'(1)),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  // saturate to the signed 16-bit range
  always_comb begin
    if (neg_q) begin
      if (quotient > DIV_QW'(32768)) begin
        td_d = -16'sd32768;
      end else begin
        td_d = -$signed(quotient[TD_W-1:0]);
      end
    end else if (quotient > DIV_QW'(32767)) begin
      td_d = 16'sd32767;
    end else begin
      td_d = $signed(quotient[TD_W-1:0]);
    end
  end

  assign abs_td    = td_q[TD_W-1] ? TD_W'(-td_q) : TD_W'(td_q);
  assign fade_prod = abs_td * color_slope_q;
  assign fade_d    = (fade_prod > (TD_W+8)'(255)) ? 8'd0 : 8'(8'd255 - fade_prod[7:0]);

  // a negative fade is carried as zero, which scales to zero as well
  function automatic logic [7:0] scale_color(input logic [7:0] c, input logic [7:0] inten);
    logic [9:0] p;
    p = c[7:3] * inten[7:3];
    return (p > 10'd255) ? 8'd255 : p[7:0];
  endfunction

  always_comb begin
    if (in_tune_q) begin
      r_c = 8'd255;
      g_c = 8'd255;
      b_c = 8'd255;
    end else if (sharp_q) begin
      r_c = 8'd255;
      g_c = fade_q;
      b_c = fade_q;
    end else begin
      r_c = fade_q;
      g_c = fade_q;
      b_c = 8'd255;
    end
  end

  assign out_load = (state_q == ST_OUT) && (!out_valid_q || out_o.ready);

  // ---- sequencer ----
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_i.valid) state_d = ST_UPD;
      ST_UPD:   state_d = ST_SCALE;
      ST_SCALE: state_d = ST_MUL;
      ST_MUL:   state_d = ST_DIV;
      ST_DIV:   if (div_done) state_d = ST_SAT;
      ST_SAT:   state_d = ST_FADE;
      ST_FADE:  state_d = ST_OUT;
      ST_OUT:   if (out_load) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      baseline_q    <= BASELINE_RST;
      gain_shift_q  <= GAIN_SHIFT_RST;
      tune_window_q <= TUNE_WINDOW_RST;
      diff_gain_q   <= DIFF_GAIN_RST;
      color_slope_q <= COLOR_SLOPE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_BASELINE:    baseline_q    <= cfg_data_i[7:0];
        CFG_GAIN_SHIFT:  gain_shift_q  <= cfg_data_i[3:0];
        CFG_TUNE_WINDOW: tune_window_q <= cfg_data_i[9:0];
        CFG_DIFF_GAIN:   diff_gain_q   <= cfg_data_i[9:0];
        CFG_COLOR_SLOPE: color_slope_q <= cfg_data_i[7:0];
        default:         ;
      endcase
    end
  end

  // integrators, wrapping within their widths
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) begin
        level_q[i] <= '0;
        slope_q[i] <= '0;
      end
    end else if (state_q == ST_UPD) begin
      level_q[slot_q] <= lvl_new;
      slope_q[slot_q] <= slp_new;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        slot_q   <= slot_over ? SLOT_W'(STRING_COUNT) : SLOT_W'(in_i.data.channel);
        center_q <= in_i.data.center_mag;
        upper_q  <= in_i.data.upper_mag;
        lower_q  <= in_i.data.lower_mag;
      end
      ST_UPD: begin
        lvl_q <= lvl_new;
        slp_q <= slp_new;
      end
      ST_SCALE: begin
        intensity_q <= intensity_d;
        neg_q       <= slp_sh[SLOPE_W-1];
        mag_q       <= slp_sh[SLOPE_W-1] ? SLOPE_W'(-slp_sh) : SLOPE_W'(slp_sh);
      end
      ST_SAT: begin
        td_q <= td_d;
      end
      ST_FADE: begin
        fade_q    <= fade_d;
        in_tune_q <= (abs_td < TD_W'(tune_window_q));
        sharp_q   <= !td_q[TD_W-1] && (td_q != '0);
      end
      ST_OUT: begin
        if (out_load) begin
          out_data_q.red        <= scale_color(r_c, intensity_q);
          out_data_q.green      <= scale_color(g_c, intensity_q);
          out_data_q.blue       <= scale_color(b_c, intensity_q);
          out_data_q.tonal_diff <= td_q;
        end
      end
      default: ;
    endcase
  end

  assign in_i.ready  = (state_q == ST_IDLE);
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

endmodule
`default_nettype wire

FILE: bench/spectral_tuner_indicator_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spectral_tuner_indicator_core_tb
// Self-checking bench for the tuner indicator core. Frames go in through a
// valid/ready stream with random gaps. A scoreboard model of the per-channel
// integrators and the colour shaping predicts the output beats; each beat is
// compared field by field with it or, for scripted rows, with a fixed result.
// Registers change in the script and between phases, while the block is idle.
// ----------------------------------------------------------------------------
module spectral_tuner_indicator_core_tb;
  import stti_pkg::*;

  localparam int unsigned STRINGS      = STRING_COUNT_DEF;
  localparam int unsigned DECAY        = DECAY_SHIFT_DEF;
  localparam int unsigned SLOTS        = STRINGS + 1;
  localparam int          MAG_MAX      = (1 << MAG_W) - 1;
  localparam int          PHASES       = 6;
  localparam int          PHASE_FRAMES = 125;
  localparam int          CALM_PHASE   = 3;
  localparam int          DRAIN_CYCLES = 40;
  localparam int          CYCLE_LIMIT  = 400000;

  typedef struct {
    bit                    is_write;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_val;
    stti_in_t              frame;
    bit                    known;
    stti_out_t             known_res;
  } tuner_step_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  stti_stream_if #(.payload_t(stti_in_t))  frame_if ();
  stti_stream_if #(.payload_t(stti_out_t)) color_if ();

  spectral_tuner_indicator_core #(
    .STRING_COUNT(STRINGS),
    .DECAY_SHIFT (DECAY)
  ) DUT (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (frame_if),
    .out_o     (color_if),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  // scoreboard copy of the block state and registers
  logic [LEVEL_W-1:0] level_acc [SLOTS] = '{default: '0};
  logic [SLOPE_W-1:0] slope_acc [SLOTS] = '{default: '0};
  logic [7:0]         baseline_r    = BASELINE_RST;
  logic [3:0]         gain_shift_r  = GAIN_SHIFT_RST;
  logic [9:0]         tune_window_r = TUNE_WINDOW_RST;
  logic [9:0]         diff_gain_r   = DIFF_GAIN_RST;
  logic [7:0]         fade_r        = COLOR_SLOPE_RST;

  stti_out_t   pending_colors [$];
  tuner_step_t script [$];
  int          fail_cnt = 0;
  int          cycle_cnt = 0;
  logic        calm;
  logic        row_known;
  stti_out_t   row_known_res;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic logic [COLOR_W-1:0] shade(longint c, longint inten);
    longint v;
    v = (c >>> 3) * (inten >>> 3);
    if (v < 0) return '0;
    if (v > 255) return '1;
    return v[COLOR_W-1:0];
  endfunction

  // advances the slot's integrators and returns the colour beat it yields
  function automatic stti_out_t predict_color(stti_in_t f);
    int unsigned slot;
    longint      lvl, slp, inten, td, r, g, b, mag;
    stti_out_t   res;
    slot = (f.channel >= STRINGS) ? STRINGS : f.channel;
    lvl = longint'(level_acc[slot]);
    lvl = lvl + longint'(f.center_mag) - (lvl >>> DECAY);
    level_acc[slot] = lvl[LEVEL_W-1:0];
    slp = longint'($signed(slope_acc[slot]));
    slp = slp + longint'(f.upper_mag) - longint'(f.lower_mag) - (slp >>> DECAY);
    slope_acc[slot] = slp[SLOPE_W-1:0];
    lvl = longint'(level_acc[slot]);
    slp = longint'($signed(slope_acc[slot]));

    inten = (lvl >>> gain_shift_r) - longint'(baseline_r);
    if (inten < 0) inten = 0;
    if (inten > 255) inten = 255;

    td = ((slp >>> gain_shift_r) * longint'(diff_gain_r)) / (inten + 1);
    if (td > 32767) td = 32767;
    if (td < -32768) td = -32768;

    mag = (td < 0) ? -td : td;
    if (mag < longint'(tune_window_r)) begin
      r = 255;
      g = 255;
      b = 255;
    end else if (td > 0) begin
      r = 255;
      g = 255 - td * longint'(fade_r);
      b = g;
    end else begin
      b = 255;
      r = 255 + td * longint'(fade_r);
      g = r;
    end
    res.red        = shade(r, inten);
    res.green      = shade(g, inten);
    res.blue       = shade(b, inten);
    res.tonal_diff = td[TD_W-1:0];
    return res;
  endfunction

  always @(posedge clk_i) begin
    stti_out_t want;
    stti_out_t got;
    if (rst_ni) begin
      if (color_if.valid && color_if.ready) begin
        got = color_if.data;
        if (pending_colors.size() == 0) begin
          fail_cnt++;
          $display("%0t unexpected beat: r=%0d g=%0d b=%0d td=%0d", $time,
                   got.red, got.green, got.blue, got.tonal_diff);
        end else begin
          want = pending_colors.pop_front();
          if (got.red !== want.red || got.green !== want.green ||
              got.blue !== want.blue || got.tonal_diff !== want.tonal_diff) begin
            fail_cnt++;
            $display("%0t mismatch: exp r=%0d g=%0d b=%0d td=%0d, got r=%0d g=%0d b=%0d td=%0d",
                     $time, want.red, want.green, want.blue, want.tonal_diff,
                     got.red, got.green, got.blue, got.tonal_diff);
          end
        end
      end
      if (frame_if.valid && frame_if.ready) begin
        want = predict_color(frame_if.data);
        pending_colors.push_back(row_known ? row_known_res : want);
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_BASELINE:    baseline_r    = cfg_data_i[7:0];
          CFG_GAIN_SHIFT:  gain_shift_r  = cfg_data_i[3:0];
          CFG_TUNE_WINDOW: tune_window_r = cfg_data_i[9:0];
          CFG_DIFF_GAIN:   diff_gain_r   = cfg_data_i[9:0];
          CFG_COLOR_SLOPE: fade_r        = cfg_data_i[7:0];
          default: ;
        endcase
      end
    end
  end

  // sink side: stalls at random about 10% of the time unless in the calm phase
  initial begin
    color_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      color_if.ready <= calm || ($urandom_range(99) >= 10);
    end
  end

  function automatic logic [MAG_W-1:0] mag_clip(int v);
    if (v < 0) return '0;
    if (v > MAG_MAX) return '1;
    return v[MAG_W-1:0];
  endfunction

  function automatic tuner_step_t frame_row(int ch, int c, int u, int l);
    tuner_step_t s = '{default: '0};
    s.frame.channel    = ch[CH_W-1:0];
    s.frame.center_mag = c[MAG_W-1:0];
    s.frame.upper_mag  = u[MAG_W-1:0];
    s.frame.lower_mag  = l[MAG_W-1:0];
    return s;
  endfunction

  function automatic tuner_step_t known_row(int ch, int c, int u, int l,
                                            int r, int g, int b, int td);
    tuner_step_t s;
    s = frame_row(ch, c, u, l);
    s.known                = 1'b1;
    s.known_res.red        = r[COLOR_W-1:0];
    s.known_res.green      = g[COLOR_W-1:0];
    s.known_res.blue       = b[COLOR_W-1:0];
    s.known_res.tonal_diff = td[TD_W-1:0];
    return s;
  endfunction

  function automatic tuner_step_t write_row(stti_cfg_idx_e idx, int val);
    tuner_step_t s = '{default: '0};
    s.is_write = 1'b1;
    s.reg_idx  = idx;
    s.reg_val  = val[CFG_DATA_W-1:0];
    return s;
  endfunction

  // random setting: mostly usable values, sometimes an extreme, sometimes
  // with junk above the register width
  function automatic logic [CFG_DATA_W-1:0] pick_setting(stti_cfg_idx_e idx);
    int unsigned pick;
    int unsigned v;
    pick = $urandom_range(7);
    case (idx)
      CFG_BASELINE:    v = (pick == 0) ? 0 : (pick == 1) ? 255 : $urandom_range(100);
      CFG_GAIN_SHIFT:  v = (pick == 0) ? 0 : (pick == 1) ? 15 : $urandom_range(9, 3);
      CFG_TUNE_WINDOW: v = (pick == 0) ? 0 : (pick == 1) ? 1023 : $urandom_range(300);
      CFG_DIFF_GAIN:   v = (pick == 0) ? 0 : (pick == 1) ? 1023 : $urandom_range(1023);
      default:         v = (pick == 0) ? 0 : (pick == 1) ? 255 : $urandom_range(40);
    endcase
    if ($urandom_range(7) == 0) begin
      if (idx == CFG_GAIN_SHIFT) v = v | ($urandom_range(63) << 4);
      else if (idx == CFG_BASELINE || idx == CFG_COLOR_SLOPE) v = v | ($urandom_range(3) << 8);
    end
    return v[CFG_DATA_W-1:0];
  endfunction

  // entered and left right after a falling edge
  task automatic send_frame(stti_in_t f, bit known, stti_out_t kres);
    while (!calm && $urandom_range(99) < 10) begin
      frame_if.valid <= 1'b0;
      cfg_we_i       <= 1'b0;
      @(negedge clk_i);
    end
    frame_if.valid <= 1'b1;
    frame_if.data  <= f;
    row_known      <= known;
    row_known_res  <= kres;
    cfg_we_i       <= 1'b0;
    do @(posedge clk_i); while (!frame_if.ready);
    @(negedge clk_i);
  endtask

  // waits until every beat is back, then writes one register
  task automatic program_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    frame_if.valid <= 1'b0;
    while (pending_colors.size() != 0) begin
      cfg_we_i <= 1'b0;
      @(negedge clk_i);
    end
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
  endtask

  initial begin
    int          n;
    int          span;
    int          ch;
    int          lvl;
    int          tilt;
    int          jit;
    stti_in_t    f;
    stti_out_t   no_res;
    stti_cfg_idx_e idx;

    rst_ni         = 1'b0;
    frame_if.valid = 1'b0;
    frame_if.data  = '0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = '0;
    cfg_data_i     = '0;
    row_known      = 1'b0;
    row_known_res  = '0;
    calm           = 1'b0;
    no_res         = '0;

    // fresh slots under reset settings: silence, full level, full tilt each way
    script.push_back(known_row(0, 0, 0, 0, 0, 0, 0, 0));
    script.push_back(known_row(1, MAG_MAX, 0, 0, 255, 255, 255, 0));
    script.push_back(known_row(2, 0, MAG_MAX, 0, 0, 0, 0, 32767));
    script.push_back(known_row(3, 0, 0, MAG_MAX, 0, 0, 0, -32768));
    script.push_back(known_row(4, MAG_MAX, MAG_MAX, MAG_MAX, 255, 255, 255, 0));
    script.push_back(frame_row(5, MAG_MAX, 20000, 0));
    script.push_back(frame_row(6, MAG_MAX, 0, 20000));
    // channel 7 folds onto the chromatic slot
    script.push_back(frame_row(7, 20000, 1000, 0));
    script.push_back(frame_row(6, 16000, 100, 0));
    script.push_back(frame_row(5, 10000, 300, 250));
    script.push_back(frame_row(5, 10000, 300, 290));
    script.push_back(frame_row(0, 'h5555, 'h2AAA, 'h5555));
    script.push_back(frame_row(0, 'h2AAA, 'h5555, 'h2AAA));
    // zero window: a zero difference goes down the flat path and stays white
    script.push_back(write_row(CFG_TUNE_WINDOW, 0));
    script.push_back(known_row(4, 0, 7, 7, 255, 255, 255, 0));
    script.push_back(frame_row(1, 3000, 40, 41));
    script.push_back(write_row(CFG_BASELINE, 0));
    script.push_back(write_row(CFG_GAIN_SHIFT, 15));
    script.push_back(write_row(CFG_DIFF_GAIN, 1023));
    script.push_back(write_row(CFG_COLOR_SLOPE, 255));
    script.push_back(write_row(CFG_TUNE_WINDOW, 1023));
    script.push_back(frame_row(2, MAG_MAX, MAG_MAX, 0));
    script.push_back(frame_row(3, MAG_MAX, 0, MAG_MAX));
    script.push_back(frame_row(6, 100, 0, 0));
    script.push_back(write_row(CFG_BASELINE, 255));
    script.push_back(write_row(CFG_GAIN_SHIFT, 0));
    script.push_back(write_row(CFG_DIFF_GAIN, 0));
    script.push_back(write_row(CFG_COLOR_SLOPE, 0));
    script.push_back(write_row(CFG_TUNE_WINDOW, 0));
    script.push_back(frame_row(1, MAG_MAX, 5, 0));
    script.push_back(frame_row(4, 12, 0, 3));
    script.push_back(write_row(CFG_BASELINE, 200));
    script.push_back(write_row(CFG_DIFF_GAIN, 1));
    script.push_back(write_row(CFG_COLOR_SLOPE, 1));
    script.push_back(write_row(CFG_TUNE_WINDOW, 1));
    script.push_back(frame_row(5, MAG_MAX, MAG_MAX, 0));
    script.push_back(frame_row(7, MAG_MAX, 0, MAG_MAX));

    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (script[i]) begin
      if (script[i].is_write) program_reg(script[i].reg_idx, script[i].reg_val);
      else send_frame(script[i].frame, script[i].known, script[i].known_res);
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      calm <= (phase == CALM_PHASE);
      idx = idx.first();
      do begin
        program_reg(idx, pick_setting(idx));
        idx = idx.next();
      end while (idx != idx.first());
      if ($urandom_range(2) == 0)
        program_reg(CFG_IDX_W'($urandom_range((1 << CFG_IDX_W) - 1,
                                              int'(CFG_COLOR_SLOPE) + 1)),
                    CFG_DATA_W'($urandom()));
      n = 0;
      while (n < PHASE_FRAMES) begin
        if ($urandom_range(9) < 2) begin
          // noise beat
          f.channel    = CH_W'($urandom());
          f.center_mag = MAG_W'($urandom());
          f.upper_mag  = MAG_W'($urandom());
          f.lower_mag  = MAG_W'($urandom());
          send_frame(f, 1'b0, no_res);
          n++;
        end else begin
          // steady tone on one channel, slightly detuned
          ch   = $urandom_range((1 << CH_W) - 1);
          lvl  = $urandom_range(MAG_MAX) >> $urandom_range(9);
          tilt = (int'($urandom_range(lvl / 2)) - lvl / 4) >>> $urandom_range(5);
          span = $urandom_range(24, 4);
          repeat (span) begin
            jit          = int'($urandom_range(lvl / 8)) - lvl / 16;
            f.channel    = ch[CH_W-1:0];
            f.center_mag = mag_clip(lvl + jit);
            f.upper_mag  = mag_clip(lvl / 3 + tilt + jit / 2);
            f.lower_mag  = mag_clip(lvl / 3 - tilt - jit / 4);
            send_frame(f, 1'b0, no_res);
            n++;
          end
        end
      end
    end

    frame_if.valid <= 1'b0;
    calm           <= 1'b0;
    while (pending_colors.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (fail_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: sim.f
design/stti_pkg.sv
design/stti_stream_if.sv
design/stti_div.sv
design/spectral_tuner_indicator_core.sv
bench/spectral_tuner_indicator_core_tb.sv
